// File: rtl/dbpt_pkg.sv
package dbpt_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int TIME_BITS   = 32;

  // the edge and level inputs are PINS_W = 4 bits wide, so IN_CH is capped at four channels
  localparam int IN_CH = (NUM_BUTTONS < 4) ? NUM_BUTTONS : 4;

  localparam int LOCK_W    = 16;
  localparam int DUR_W     = 32;
  localparam int CHAN_W    = 2;
  localparam int PINS_W    = 4;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 16'h0010;

  // register index, taken from paddr above the byte offset
  localparam logic REG_LOCKOUT = 1'b0;

  typedef struct packed {
    logic              event_valid;
    logic [CHAN_W-1:0] event_channel;
    logic [DUR_W-1:0]  event_duration;
    logic [PINS_W-1:0] pressed_mask;
  } res_t;

endpackage

// File: rtl/dbpt_cfg.sv
module dbpt_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [dbpt_pkg::PDATA_W-1:0]  pwdata,
  output logic [dbpt_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [dbpt_pkg::LOCK_W-1:0]   lockout_ticks
);
  import dbpt_pkg::*;

  logic reg_index;
  logic wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[PADDR_W-1];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks <= LOCKOUT_RESET;
    end else if (wr_en && (reg_index == REG_LOCKOUT)) begin
      lockout_ticks <= pwdata[LOCK_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_LOCKOUT: prdata = PDATA_W'(lockout_ticks);
      default:     prdata = '0;
    endcase
  end

endmodule

// File: rtl/dbpt_core.sv
module dbpt_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [dbpt_pkg::PINS_W-1:0]   edge_mask,
  input  logic [dbpt_pkg::PINS_W-1:0]   pin_levels,
  input  logic [dbpt_pkg::LOCK_W-1:0]   lockout_ticks,
  output dbpt_pkg::res_t                res
);
  import dbpt_pkg::*;

  logic [TIME_BITS-1:0] tick_count;
  logic [LOCK_W-1:0]    lockout_left;
  logic [CHAN_W-1:0]    pending_channel;
  logic [TIME_BITS-1:0] press_start [IN_CH];
  logic [IN_CH-1:0]     armed_flag;

  logic [TIME_BITS-1:0] tick_count_next;
  logic [LOCK_W-1:0]    lockout_left_next;
  logic [CHAN_W-1:0]    pending_channel_next;
  logic [IN_CH-1:0]     armed_flag_next;
  logic [IN_CH-1:0]     start_load;
  logic [LOCK_W-1:0]    lock_mid;
  logic                 expire;
  logic                 pin_low;
  logic                 armed_sel;
  logic [TIME_BITS-1:0] start_sel;
  logic                 edge_found;
  logic [CHAN_W-1:0]    edge_chan;

  always_comb begin
    lock_mid = (lockout_left != '0) ? (lockout_left - LOCK_W'(1)) : '0;
    expire   = (lockout_left == LOCK_W'(1));
    pin_low  = ~pin_levels[pending_channel];

    armed_sel = 1'b0;
    start_sel = '0;
    for (int i = 0; i < IN_CH; i++) begin
      if (pending_channel == CHAN_W'(i)) begin
        armed_sel = armed_flag[i];
        start_sel = press_start[i];
      end
    end

    // lowest-numbered edge wins
    edge_found = 1'b0;
    edge_chan  = '0;
    for (int i = IN_CH - 1; i >= 0; i--) begin
      if (edge_mask[i]) begin
        edge_found = 1'b1;
        edge_chan  = CHAN_W'(i);
      end
    end

    start_load      = '0;
    armed_flag_next = armed_flag;
    res             = '0;
    res.pressed_mask = ~pin_levels;
    for (int i = 0; i < IN_CH; i++) begin
      if (expire && (pending_channel == CHAN_W'(i))) begin
        if (pin_low) begin
          start_load[i]      = 1'b1;
          armed_flag_next[i] = 1'b1;
        end else if (armed_flag[i]) begin
          armed_flag_next[i] = 1'b0;
        end
      end
    end
    if (expire && !pin_low && armed_sel) begin
      res.event_valid    = 1'b1;
      res.event_channel  = pending_channel;
      res.event_duration = DUR_W'(tick_count - start_sel);
    end

    lockout_left_next    = lock_mid;
    pending_channel_next = pending_channel;
    if ((lock_mid == '0) && edge_found) begin
      pending_channel_next = edge_chan;
      lockout_left_next    = (lockout_ticks != '0) ? lockout_ticks : LOCK_W'(1);
    end

    tick_count_next = tick_count + TIME_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      lockout_left    <= '0;
      pending_channel <= '0;
      armed_flag      <= '0;
    end else if (accept) begin
      tick_count      <= tick_count_next;
      lockout_left    <= lockout_left_next;
      pending_channel <= pending_channel_next;
      armed_flag      <= armed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < IN_CH; i++) begin
      if (rst) begin
        press_start[i] <= '0;
      end else if (accept && start_load[i]) begin
        press_start[i] <= tick_count;
      end
    end
  end

endmodule

// File: rtl/dbpt_outbuf.sv
module dbpt_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dbpt_pkg::res_t push_data,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output dbpt_pkg::res_t out_data
);
  import dbpt_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload path, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

// File: rtl/debounced_button_press_timer_unit.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  edge_mask, pin_levels
// out      output     out_valid/out_stall  event_valid, event_channel,
//                                          event_duration, pressed_mask
// cfg      input      apb psel/penable     lockout_ticks at byte address 0
//
// one tick per cycle while in_stall is low: the timer state updates at the
// accepting edge, and the result enters the output buffer at that same edge
// a two-entry output buffer (register plus skid) lets a tick be taken while a
// result waits; in_stall rises only when both entries are full
// rst is synchronous: lockout idle, tick count, press starts and arming cleared,
// lockout_ticks back to 16
module debounced_button_press_timer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dbpt_pkg::PINS_W-1:0]   edge_mask,
  input  logic [dbpt_pkg::PINS_W-1:0]   pin_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          event_valid,
  output logic [dbpt_pkg::CHAN_W-1:0]   event_channel,
  output logic [dbpt_pkg::DUR_W-1:0]    event_duration,
  output logic [dbpt_pkg::PINS_W-1:0]   pressed_mask,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbpt_pkg::PADDR_W-1:0]  paddr,
  input  logic [dbpt_pkg::PDATA_W-1:0]  pwdata,
  output logic [dbpt_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import dbpt_pkg::*;

  logic              accept;
  logic [LOCK_W-1:0] lockout_ticks;
  res_t              core_res;
  res_t              out_res;

  assign accept = in_valid && !in_stall;

  dbpt_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .lockout_ticks (lockout_ticks)
  );

  dbpt_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .edge_mask     (edge_mask),
    .pin_levels    (pin_levels),
    .lockout_ticks (lockout_ticks),
    .res           (core_res)
  );

  dbpt_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign event_valid    = out_res.event_valid;
  assign event_channel  = out_res.event_channel;
  assign event_duration = out_res.event_duration;
  assign pressed_mask   = out_res.pressed_mask;

`ifndef ASSERT_OFF
  // skid entry is only ever filled behind a full output register
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // the buffer can only fill up while the output side is stalled
  a_stall_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_stall))
    else $error("input stall rose without output stall");

  // no event means zero channel and duration
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !event_valid) |-> (event_channel == '0 && event_duration == '0))
    else $error("nonzero event fields without event");
`endif

endmodule
